[src/mcs_pkg.sv]
// ----------------------------------------------------------------------------
// mcs_pkg
// Shared sizes, microcode types and the program ROM of the clique search.
// ----------------------------------------------------------------------------
package mcs_pkg;

  // graph size and derived widths
  localparam int MAX_VERTS = 16;
  localparam int SET_W     = MAX_VERTS;
  localparam int VIDX_W    = (MAX_VERTS > 1) ? $clog2(MAX_VERTS) : 1;
  localparam int CNT_W     = $clog2(MAX_VERTS + 1);

  // fixed field widths of the channels
  localparam int KIND_W    = 1;
  localparam int IDX_W     = 4;
  localparam int ROW_W     = 16;
  localparam int CSZ_W     = 5;
  localparam int VCNT_W    = 5;

  // configuration port
  localparam int APB_AW    = 3;
  localparam int APB_DW    = 32;
  localparam logic [VCNT_W-1:0] VERTEX_COUNT_RST = VCNT_W'(16);

  // register indexes (word address bits)
  localparam logic REG_VERTEX_COUNT = 1'b0;

  // input item kinds
  localparam logic KIND_LOAD = 1'b0;
  localparam logic KIND_RUN  = 1'b1;

  // datapath operations
  typedef enum logic [3:0] {
    OP_NOP,
    OP_INIT,
    OP_LOW,
    OP_NB,
    OP_PUSH,
    OP_REC,
    OP_POP,
    OP_SCAN0,
    OP_SKIP,
    OP_SHOW,
    OP_EMPTY
  } op_t;

  // jump conditions
  typedef enum logic [3:0] {
    C_NONE,
    C_ALWAYS,
    C_NO_RUN,
    C_N_ZERO,
    C_PRUNE,
    C_POOL_ZERO,
    C_SP_ZERO,
    C_BIT_SET,
    C_OUT_BUSY,
    C_LAST
  } cond_t;

  // program steps
  typedef enum logic [4:0] {
    P_IDLE,
    P_CHKN,
    P_INIT,
    P_CALL,
    P_LEAF,
    P_LOW,
    P_NB,
    P_PUSH,
    P_REC,
    P_RET,
    P_POP,
    P_SCAN0,
    P_SCAN,
    P_SKIP,
    P_OWAIT,
    P_SHOW,
    P_NEXTV,
    P_EWAIT,
    P_EMPTY
  } step_t;

  // one control word
  typedef struct packed {
    op_t   op;
    logic  accept;
    cond_t cond;
    step_t target;
  } ctrl_t;

  // datapath status seen by the sequencer
  typedef struct packed {
    logic no_run;
    logic n_zero;
    logic prune;
    logic pool_zero;
    logic sp_zero;
    logic bit_set;
    logic out_busy;
    logic last;
  } stat_t;

  // program rom
  function automatic ctrl_t prog_word(step_t s);
    ctrl_t w;
    w = '{op: OP_NOP, accept: 1'b0, cond: C_NONE, target: P_IDLE};
    case (s)
      P_IDLE:  w = '{op: OP_NOP,   accept: 1'b1, cond: C_NO_RUN,    target: P_IDLE};
      P_CHKN:  w = '{op: OP_NOP,   accept: 1'b0, cond: C_N_ZERO,    target: P_EWAIT};
      P_INIT:  w = '{op: OP_INIT,  accept: 1'b0, cond: C_NONE,      target: P_IDLE};
      P_CALL:  w = '{op: OP_NOP,   accept: 1'b0, cond: C_PRUNE,     target: P_RET};
      P_LEAF:  w = '{op: OP_NOP,   accept: 1'b0, cond: C_POOL_ZERO, target: P_REC};
      P_LOW:   w = '{op: OP_LOW,   accept: 1'b0, cond: C_NONE,      target: P_IDLE};
      P_NB:    w = '{op: OP_NB,    accept: 1'b0, cond: C_NONE,      target: P_IDLE};
      P_PUSH:  w = '{op: OP_PUSH,  accept: 1'b0, cond: C_ALWAYS,    target: P_CALL};
      P_REC:   w = '{op: OP_REC,   accept: 1'b0, cond: C_NONE,      target: P_IDLE};
      P_RET:   w = '{op: OP_NOP,   accept: 1'b0, cond: C_SP_ZERO,   target: P_SCAN0};
      P_POP:   w = '{op: OP_POP,   accept: 1'b0, cond: C_ALWAYS,    target: P_CALL};
      P_SCAN0: w = '{op: OP_SCAN0, accept: 1'b0, cond: C_NONE,      target: P_IDLE};
      P_SCAN:  w = '{op: OP_NOP,   accept: 1'b0, cond: C_BIT_SET,   target: P_OWAIT};
      P_SKIP:  w = '{op: OP_SKIP,  accept: 1'b0, cond: C_ALWAYS,    target: P_SCAN};
      P_OWAIT: w = '{op: OP_NOP,   accept: 1'b0, cond: C_OUT_BUSY,  target: P_OWAIT};
      P_SHOW:  w = '{op: OP_SHOW,  accept: 1'b0, cond: C_LAST,      target: P_IDLE};
      P_NEXTV: w = '{op: OP_NOP,   accept: 1'b0, cond: C_ALWAYS,    target: P_SCAN};
      P_EWAIT: w = '{op: OP_NOP,   accept: 1'b0, cond: C_OUT_BUSY,  target: P_EWAIT};
      P_EMPTY: w = '{op: OP_EMPTY, accept: 1'b0, cond: C_ALWAYS,    target: P_IDLE};
      default: w = '{op: OP_NOP,   accept: 1'b0, cond: C_ALWAYS,    target: P_IDLE};
    endcase
    return w;
  endfunction

endpackage

[src/mcs_in_if.sv]
// ----------------------------------------------------------------------------
// mcs_in_if
// Input channel: adjacency row loads and search requests.
// ----------------------------------------------------------------------------
interface mcs_in_if;
  logic                       valid;
  logic                       ready;
  logic [mcs_pkg::KIND_W-1:0] kind;
  logic [mcs_pkg::IDX_W-1:0]  row_index;
  logic [mcs_pkg::ROW_W-1:0]  row_bits;

  modport source (output valid, output kind, output row_index, output row_bits,
                  input ready);
  modport sink   (input valid, input kind, input row_index, input row_bits,
                  output ready);
endinterface

[src/mcs_out_if.sv]
// ----------------------------------------------------------------------------
// mcs_out_if
// Result channel: one clique member per transfer.
// ----------------------------------------------------------------------------
interface mcs_out_if;
  logic                      valid;
  logic                      ready;
  logic [mcs_pkg::IDX_W-1:0] member_index;
  logic [mcs_pkg::CSZ_W-1:0] clique_size;
  logic                      is_last;
  logic                      is_empty;

  modport source (output valid, output member_index, output clique_size,
                  output is_last, output is_empty, input ready);
  modport sink   (input valid, input member_index, input clique_size,
                  input is_last, input is_empty, output ready);
endinterface

[src/mcs_seq.sv]
// ----------------------------------------------------------------------------
// mcs_seq
// Microcode sequencer: step counter, program rom and conditional jumps.
// ----------------------------------------------------------------------------
module mcs_seq (
  input  logic            clk,
  input  logic            rst_n,
  input  mcs_pkg::stat_t  stat,
  output mcs_pkg::ctrl_t  ctrl
);

  mcs_pkg::step_t pc_r;
  mcs_pkg::step_t pc_nxt;
  mcs_pkg::ctrl_t word;
  logic           take;

  // control word of the current step
  always_comb begin
    word = mcs_pkg::prog_word(pc_r);
    ctrl = word;
  end

  // condition select and next step
  always_comb begin
    case (word.cond)
      mcs_pkg::C_NONE:      take = 1'b0;
      mcs_pkg::C_ALWAYS:    take = 1'b1;
      mcs_pkg::C_NO_RUN:    take = stat.no_run;
      mcs_pkg::C_N_ZERO:    take = stat.n_zero;
      mcs_pkg::C_PRUNE:     take = stat.prune;
      mcs_pkg::C_POOL_ZERO: take = stat.pool_zero;
      mcs_pkg::C_SP_ZERO:   take = stat.sp_zero;
      mcs_pkg::C_BIT_SET:   take = stat.bit_set;
      mcs_pkg::C_OUT_BUSY:  take = stat.out_busy;
      mcs_pkg::C_LAST:      take = stat.last;
      default:              take = 1'b0;
    endcase
    if (take) begin
      pc_nxt = word.target;
    end else begin
      pc_nxt = mcs_pkg::step_t'(pc_r + 5'd1);
    end
  end

  // step counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= mcs_pkg::P_IDLE;
    end else begin
      pc_r <= pc_nxt;
    end
  end

endmodule

[src/mcs_dp.sv]
// ----------------------------------------------------------------------------
// mcs_dp
// Search datapath: adjacency rows, pool and candidate registers, the call
// stack of pending exclude branches, best clique and the result register.
// ----------------------------------------------------------------------------
module mcs_dp (
  input  logic                         clk,
  input  logic                         rst_n,
  input  mcs_pkg::ctrl_t               ctrl,
  input  logic [mcs_pkg::VCNT_W-1:0]   vertex_count,
  mcs_in_if.sink                       in_ch,
  mcs_out_if.source                    out_ch,
  output mcs_pkg::stat_t               stat
);

  localparam int SET_W  = mcs_pkg::SET_W;
  localparam int VIDX_W = mcs_pkg::VIDX_W;
  localparam int CNT_W  = mcs_pkg::CNT_W;

  // storage
  logic [SET_W-1:0]  adj_r [mcs_pkg::MAX_VERTS];
  logic [SET_W-1:0]  stk_pool_r [mcs_pkg::MAX_VERTS];
  logic [SET_W-1:0]  stk_cand_r [mcs_pkg::MAX_VERTS];

  // working registers
  logic [SET_W-1:0]  pool_r, pool_nxt;
  logic [SET_W-1:0]  cand_r, cand_nxt;
  logic [SET_W-1:0]  all_r, all_nxt;
  logic [SET_W-1:0]  nb_r, nb_nxt;
  logic [SET_W-1:0]  best_set_r, best_set_nxt;
  logic [CNT_W-1:0]  best_size_r, best_size_nxt;
  logic [CNT_W-1:0]  sp_r, sp_nxt;
  logic [VIDX_W-1:0] v_r, v_nxt;
  logic [VIDX_W-1:0] e_r, e_nxt;
  logic [CNT_W-1:0]  k_r, k_nxt;

  // result register
  logic                      out_valid_r, out_valid_nxt;
  logic [mcs_pkg::IDX_W-1:0] out_member_r, out_member_nxt;
  logic [mcs_pkg::CSZ_W-1:0] out_size_r, out_size_nxt;
  logic                      out_last_r, out_last_nxt;
  logic                      out_empty_r, out_empty_nxt;

  // combinational helpers
  logic                      in_xfer;
  logic                      row_wr;
  logic [SET_W-1:0]          row_ext;
  logic [VIDX_W-1:0]         row_addr;
  logic [SET_W-1:0]          all_c;
  logic [CNT_W-1:0]          pop_c;
  logic [CNT_W:0]            bound_c;
  logic [VIDX_W-1:0]         low_c;
  logic [SET_W-1:0]          nb_c;
  logic [SET_W-1:0]          vbit_c;
  logic [VIDX_W-1:0]         top_idx;
  logic [VIDX_W-1:0]         pop_idx;
  logic [CNT_W:0]            k_inc;
  logic                      last_c;
  logic                      push_en;

  // input handshake
  assign in_ch.ready = ctrl.accept;
  assign in_xfer     = in_ch.valid & in_ch.ready;
  assign row_wr      = in_xfer && (in_ch.kind == mcs_pkg::KIND_LOAD)
                       && (int'(in_ch.row_index) < mcs_pkg::MAX_VERTS);
  assign row_addr    = VIDX_W'(in_ch.row_index);

  // row bits resized to the vertex set width
  always_comb begin
    logic [SET_W+mcs_pkg::ROW_W-1:0] ext;
    ext     = {{SET_W{1'b0}}, in_ch.row_bits};
    row_ext = ext[SET_W-1:0];
  end

  // mask of vertices taking part, saturates at the set width
  always_comb begin
    for (int u = 0; u < SET_W; u++) begin
      all_c[u] = (u < int'(vertex_count));
    end
  end

  // pruning bound: depth plus remaining pool against best size
  always_comb begin
    pop_c = '0;
    for (int i = 0; i < SET_W; i++) begin
      pop_c = pop_c + CNT_W'(pool_r[i]);
    end
    bound_c = {1'b0, sp_r} + {1'b0, pop_c};
  end

  // lowest vertex left in the pool
  always_comb begin
    low_c = '0;
    for (int i = SET_W - 1; i >= 0; i--) begin
      if (pool_r[i]) begin
        low_c = VIDX_W'(i);
      end
    end
  end

  // symmetric neighbor set of the chosen vertex, self loop dropped
  always_comb begin
    for (int u = 0; u < SET_W; u++) begin
      nb_c[u] = (VIDX_W'(u) != v_r) && (adj_r[v_r][u] || adj_r[u][v_r]) && all_r[u];
      vbit_c[u] = (VIDX_W'(u) == v_r);
    end
  end

  // stack addresses and emit bookkeeping
  assign top_idx = sp_r[VIDX_W-1:0];
  always_comb begin
    logic [CNT_W-1:0] spm1;
    spm1    = sp_r - CNT_W'(1);
    pop_idx = spm1[VIDX_W-1:0];
  end
  assign k_inc   = {1'b0, k_r} + (CNT_W+1)'(1);
  assign last_c  = (k_inc == {1'b0, best_size_r});
  assign push_en = (ctrl.op == mcs_pkg::OP_PUSH);

  // status to the sequencer
  always_comb begin
    stat.no_run    = !(in_xfer && (in_ch.kind == mcs_pkg::KIND_RUN));
    stat.n_zero    = (vertex_count == '0);
    stat.prune     = (bound_c <= {1'b0, best_size_r});
    stat.pool_zero = (pool_r == '0);
    stat.sp_zero   = (sp_r == '0);
    stat.bit_set   = best_set_r[e_r];
    stat.out_busy  = out_valid_r & ~out_ch.ready;
    stat.last      = last_c;
  end

  // next values per operation
  always_comb begin
    pool_nxt      = pool_r;
    cand_nxt      = cand_r;
    all_nxt       = all_r;
    nb_nxt        = nb_r;
    best_set_nxt  = best_set_r;
    best_size_nxt = best_size_r;
    sp_nxt        = sp_r;
    v_nxt         = v_r;
    e_nxt         = e_r;
    k_nxt         = k_r;
    out_member_nxt = out_member_r;
    out_size_nxt   = out_size_r;
    out_last_nxt   = out_last_r;
    out_empty_nxt  = out_empty_r;
    out_valid_nxt  = out_valid_r & ~out_ch.ready;
    case (ctrl.op)
      mcs_pkg::OP_INIT: begin
        all_nxt       = all_c;
        pool_nxt      = all_c;
        cand_nxt      = '0;
        best_set_nxt  = '0;
        best_size_nxt = '0;
        sp_nxt        = '0;
      end
      mcs_pkg::OP_LOW: begin
        v_nxt = low_c;
      end
      mcs_pkg::OP_NB: begin
        nb_nxt = nb_c;
      end
      mcs_pkg::OP_PUSH: begin
        pool_nxt = pool_r & nb_r;
        cand_nxt = cand_r | vbit_c;
        sp_nxt   = sp_r + CNT_W'(1);
      end
      mcs_pkg::OP_REC: begin
        best_size_nxt = sp_r;
        best_set_nxt  = cand_r;
      end
      mcs_pkg::OP_POP: begin
        pool_nxt = stk_pool_r[pop_idx];
        cand_nxt = stk_cand_r[pop_idx];
        sp_nxt   = sp_r - CNT_W'(1);
      end
      mcs_pkg::OP_SCAN0: begin
        e_nxt = '0;
        k_nxt = '0;
      end
      mcs_pkg::OP_SKIP: begin
        e_nxt = e_r + VIDX_W'(1);
      end
      mcs_pkg::OP_SHOW: begin
        out_valid_nxt  = 1'b1;
        out_member_nxt = mcs_pkg::IDX_W'(e_r);
        out_size_nxt   = mcs_pkg::CSZ_W'(best_size_r);
        out_last_nxt   = last_c;
        out_empty_nxt  = 1'b0;
        e_nxt          = e_r + VIDX_W'(1);
        k_nxt          = k_inc[CNT_W-1:0];
      end
      mcs_pkg::OP_EMPTY: begin
        out_valid_nxt  = 1'b1;
        out_member_nxt = '0;
        out_size_nxt   = '0;
        out_last_nxt   = 1'b1;
        out_empty_nxt  = 1'b1;
        best_set_nxt   = '0;
        best_size_nxt  = '0;
        cand_nxt       = '0;
      end
      default: begin
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sp_r        <= '0;
      best_size_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      sp_r        <= sp_nxt;
      best_size_r <= best_size_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    pool_r       <= pool_nxt;
    cand_r       <= cand_nxt;
    all_r        <= all_nxt;
    nb_r         <= nb_nxt;
    best_set_r   <= best_set_nxt;
    v_r          <= v_nxt;
    e_r          <= e_nxt;
    k_r          <= k_nxt;
    out_member_r <= out_member_nxt;
    out_size_r   <= out_size_nxt;
    out_last_r   <= out_last_nxt;
    out_empty_r  <= out_empty_nxt;
  end

  // adjacency row write
  always_ff @(posedge clk) begin
    if (row_wr) begin
      adj_r[row_addr] <= row_ext;
    end
  end

  // save the exclude branch on every include
  always_ff @(posedge clk) begin
    if (push_en) begin
      stk_pool_r[top_idx] <= pool_r & ~vbit_c;
      stk_cand_r[top_idx] <= cand_r;
    end
  end

  // result channel
  assign out_ch.valid        = out_valid_r;
  assign out_ch.member_index = out_member_r;
  assign out_ch.clique_size  = out_size_r;
  assign out_ch.is_last      = out_last_r;
  assign out_ch.is_empty     = out_empty_r;

endmodule

[src/max_clique_search_unit.sv]
// ----------------------------------------------------------------------------
// max_clique_search_unit
// Brute force maximum clique search over a loaded adjacency matrix.
// ----------------------------------------------------------------------------
// Row loads are accepted back to back while idle.
// A search runs a setup, then visits every node of the
// include/exclude tree (exponential in vertex count, pruned by best size so
// far), then scans the vertices and emits the members; output stalls hold it.
// Reset (rst_n, synchronous): vertex_count returns to 16, no result pending;
// adjacency rows are undefined until written and get no clearing pass.
module max_clique_search_unit (
  input  logic                          clk,
  input  logic                          rst_n,
  mcs_in_if.sink                        in_ch,
  mcs_out_if.source                     out_ch,
  input  logic                          cfg_psel,
  input  logic                          cfg_penable,
  input  logic                          cfg_pwrite,
  input  logic [mcs_pkg::APB_AW-1:0]    cfg_paddr,
  input  logic [mcs_pkg::APB_DW-1:0]    cfg_pwdata,
  output logic [mcs_pkg::APB_DW-1:0]    cfg_prdata,
  output logic                          cfg_pready
);

  logic [mcs_pkg::VCNT_W-1:0] vertex_count_r, vertex_count_nxt;
  logic                       cfg_wr;
  logic                       cfg_hit;
  mcs_pkg::ctrl_t             ctrl;
  mcs_pkg::stat_t             stat;

  // register file transfer decode
  assign cfg_pready = 1'b1;
  assign cfg_hit    = (cfg_paddr[2] == mcs_pkg::REG_VERTEX_COUNT);
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready & cfg_hit;

  always_comb begin
    vertex_count_nxt = vertex_count_r;
    if (cfg_wr) begin
      vertex_count_nxt = cfg_pwdata[mcs_pkg::VCNT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vertex_count_r <= mcs_pkg::VERTEX_COUNT_RST;
    end else begin
      vertex_count_r <= vertex_count_nxt;
    end
  end

  // read back
  always_comb begin
    cfg_prdata = '0;
    if (cfg_hit) begin
      cfg_prdata = mcs_pkg::APB_DW'(vertex_count_r);
    end
  end

  // microcode sequencer
  mcs_seq u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .stat  (stat),
    .ctrl  (ctrl)
  );

  // search datapath
  mcs_dp u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .ctrl         (ctrl),
    .vertex_count (vertex_count_r),
    .in_ch        (in_ch),
    .out_ch       (out_ch),
    .stat         (stat)
  );

endmodule

[sim/max_clique_search_checker.sv]
// ----------------------------------------------------------------------------
// max_clique_search_checker
// Watches the row/search channel, the member channel and the register port of
// the clique search unit. Keeps its own adjacency matrix and vertex count,
// works out the expected clique members for every search transfer, and
// compares each member transfer against the oldest expected one.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module max_clique_search_checker (
  input  logic                       clk,
  input  logic                       rst_n,
  mcs_in_if                          in_ch,
  mcs_out_if                         out_ch,
  input  logic                       cfg_psel,
  input  logic                       cfg_penable,
  input  logic                       cfg_pwrite,
  input  logic [mcs_pkg::APB_AW-1:0] cfg_paddr,
  input  logic [mcs_pkg::APB_DW-1:0] cfg_pwdata,
  input  logic [mcs_pkg::APB_DW-1:0] cfg_prdata,
  input  logic                       cfg_pready,
  output int                         error_count,
  output int                         outstanding
);
  import mcs_pkg::*;

  // one expected member transfer
  typedef struct packed {
    logic [IDX_W-1:0] mem_idx;
    logic [CSZ_W-1:0] csize;
    logic             last_flag;
    logic             empty_flag;
  } clique_member_t;

  clique_member_t     clique_members_q[$];
  logic [ROW_W-1:0]   adj_rows [MAX_VERTS];
  logic [VCNT_W-1:0]  vcount_reg;

  initial begin
    error_count = 0;
    outstanding = 0;
  end

  task automatic report_mismatch(input string msg);
    $display("%0t ns: mismatch: %s", $time, msg);
    error_count++;
  endtask

  // lexicographically first maximum clique, include-before-exclude search
  task automatic predict_clique();
    logic [SET_W-1:0] nb [MAX_VERTS];
    logic [SET_W-1:0] pool_st [MAX_VERTS+2];
    int               size_st [MAX_VERTS+2];
    int               step_st [MAX_VERTS+2];
    int               vert_st [MAX_VERTS+2];
    logic [SET_W-1:0] all_mask;
    logic [SET_W-1:0] cand;
    logic [SET_W-1:0] best;
    logic [SET_W:0]   span;
    clique_member_t   m;
    int               n;
    int               sp;
    int               best_n;
    int               v;
    int               k;

    n = (vcount_reg > VCNT_W'(MAX_VERTS)) ? MAX_VERTS : int'(vcount_reg);

    // no vertices: a single empty-flagged transfer
    if (n == 0) begin
      m = '{mem_idx: '0, csize: '0, last_flag: 1'b1, empty_flag: 1'b1};
      clique_members_q.push_back(m);
      return;
    end

    span = ({{SET_W{1'b0}}, 1'b1} << n) - 1'b1;
    all_mask = span[SET_W-1:0];

    // symmetric neighbor sets, self loops and far vertices dropped
    for (int a = 0; a < MAX_VERTS; a++) begin
      nb[a] = '0;
      for (int b = 0; b < MAX_VERTS; b++) begin
        if (a < n && b < n && a != b && (adj_rows[a][b] || adj_rows[b][a]))
          nb[a][b] = 1'b1;
      end
    end

    // explicit stack: step 0 = enter, 1 = after include, 2 = done
    best = '0;
    best_n = 0;
    cand = '0;
    sp = 0;
    pool_st[0] = all_mask;
    size_st[0] = 0;
    step_st[0] = 0;
    while (sp >= 0) begin
      case (step_st[sp])
        0: begin
          if (size_st[sp] + $countones(pool_st[sp]) <= best_n) begin
            sp--;
          end else if (pool_st[sp] == '0) begin
            best_n = size_st[sp];
            best = cand;
            sp--;
          end else begin
            v = 0;
            while (!pool_st[sp][v]) v++;
            vert_st[sp] = v;
            cand[v] = 1'b1;
            step_st[sp] = 1;
            pool_st[sp+1] = pool_st[sp] & nb[v];
            size_st[sp+1] = size_st[sp] + 1;
            step_st[sp+1] = 0;
            sp++;
          end
        end
        1: begin
          v = vert_st[sp];
          cand[v] = 1'b0;
          step_st[sp] = 2;
          pool_st[sp+1] = pool_st[sp];
          pool_st[sp+1][v] = 1'b0;
          size_st[sp+1] = size_st[sp];
          step_st[sp+1] = 0;
          sp++;
        end
        default: sp--;
      endcase
    end

    // members in ascending order, last one flagged
    k = 0;
    for (int a = 0; a < n; a++) begin
      if (best[a]) begin
        m.mem_idx    = IDX_W'(a);
        m.csize      = CSZ_W'(best_n);
        m.last_flag  = (k + 1 == best_n);
        m.empty_flag = 1'b0;
        clique_members_q.push_back(m);
        k++;
      end
    end
  endtask

  // monitor all three ports at the clock edge
  always @(posedge clk) begin
    clique_member_t want;
    if (!rst_n) begin
      clique_members_q.delete();
      vcount_reg = VERTEX_COUNT_RST;
      for (int a = 0; a < MAX_VERTS; a++) adj_rows[a] = '0;
      outstanding <= 0;
    end else begin
      // register writes and read-back
      if (cfg_psel && cfg_penable && cfg_pready &&
          cfg_paddr[APB_AW-1:2] == REG_VERTEX_COUNT) begin
        if (cfg_pwrite)
          vcount_reg = cfg_pwdata[VCNT_W-1:0];
        else if (cfg_prdata !== APB_DW'(vcount_reg))
          report_mismatch($sformatf("vertex_count read %0h expected %0h",
                                    cfg_prdata, vcount_reg));
      end

      // member transfer against the oldest expected one
      if (out_ch.valid && out_ch.ready) begin
        if (clique_members_q.size() == 0) begin
          report_mismatch($sformatf("member transfer %0d with nothing pending",
                                    out_ch.member_index));
        end else begin
          want = clique_members_q.pop_front();
          if (out_ch.member_index !== want.mem_idx)
            report_mismatch($sformatf("member_index got %0d expected %0d",
                                      out_ch.member_index, want.mem_idx));
          if (out_ch.clique_size !== want.csize)
            report_mismatch($sformatf("clique_size got %0d expected %0d",
                                      out_ch.clique_size, want.csize));
          if (out_ch.is_last !== want.last_flag)
            report_mismatch($sformatf("is_last got %0b expected %0b",
                                      out_ch.is_last, want.last_flag));
          if (out_ch.is_empty !== want.empty_flag)
            report_mismatch($sformatf("is_empty got %0b expected %0b",
                                      out_ch.is_empty, want.empty_flag));
        end
      end

      // row load or search request
      if (in_ch.valid && in_ch.ready) begin
        if (in_ch.kind == KIND_LOAD)
          adj_rows[in_ch.row_index] = in_ch.row_bits;
        else
          predict_clique();
      end

      outstanding <= clique_members_q.size();
    end
  end

endmodule

[sim/max_clique_search_unit_tb.sv]
// ----------------------------------------------------------------------------
// max_clique_search_unit_tb
// Drives row loads, searches and vertex count writes into the clique search
// unit with random source gaps and sink stalls; the checker beside the unit
// predicts and compares every member transfer.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module max_clique_search_unit_tb;
  import mcs_pkg::*;

  localparam int          RANDOM_ITEMS = 260;
  localparam int          IDLE_SETTLE  = 16;
  localparam int          END_SETTLE   = 64;
  localparam int unsigned CYCLE_LIMIT  = 2000000;
  localparam logic [APB_AW-1:0] VCOUNT_ADDR = {REG_VERTEX_COUNT, 2'b00};

  // edge density of a loaded row
  typedef enum int {
    DENS_HALF,
    DENS_QUARTER,
    DENS_EIGHTH,
    DENS_FULL,
    DENS_NONE,
    DENS_HEAVY
  } density_t;

  logic              clk;
  logic              rst_n;
  logic              cfg_psel;
  logic              cfg_penable;
  logic              cfg_pwrite;
  logic [APB_AW-1:0] cfg_paddr;
  logic [APB_DW-1:0] cfg_pwdata;
  logic [APB_DW-1:0] cfg_prdata;
  logic              cfg_pready;

  int                mismatches;
  int                outstanding;
  int                items_sent;
  int                sink_hold;
  int unsigned       cycle_count;
  bit                src_steady;
  bit                sink_steady;

  mcs_in_if  in_ch ();
  mcs_out_if out_ch ();

  max_clique_search_unit u_top (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  max_clique_search_checker u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .error_count (mismatches),
    .outstanding (outstanding)
  );

  // clock
  initial clk = 1'b0;
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // run limit
  initial cycle_count = 0;
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // idle length: mostly short, a few long
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [ROW_W-1:0] rand_row(input density_t d);
    case (d)
      DENS_HALF:    return ROW_W'($urandom);
      DENS_QUARTER: return ROW_W'($urandom & $urandom);
      DENS_EIGHTH:  return ROW_W'($urandom & $urandom & $urandom);
      DENS_FULL:    return '1;
      DENS_NONE:    return '0;
      default:      return ROW_W'($urandom | $urandom);
    endcase
  endfunction

  // result sink with random stalls
  initial sink_hold = 0;
  always @(posedge clk) begin
    if (sink_hold > 0) begin
      out_ch.ready <= 1'b0;
      sink_hold <= sink_hold - 1;
    end else if (!sink_steady && $urandom_range(0, 3) == 0) begin
      out_ch.ready <= 1'b0;
      sink_hold <= idle_len() - 1;
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  // one input transfer, then an optional gap
  task automatic put_item(input logic [KIND_W-1:0] kind, input logic [IDX_W-1:0] idx,
                          input logic [ROW_W-1:0] bits);
    int gap;
    in_ch.valid     <= 1'b1;
    in_ch.kind      <= kind;
    in_ch.row_index <= idx;
    in_ch.row_bits  <= bits;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    items_sent++;
    gap = (src_steady || $urandom_range(0, 2) != 0) ? 0 : idle_len();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // search request with don't-care payload
  task automatic start_search();
    put_item(KIND_RUN, IDX_W'($urandom), ROW_W'($urandom));
  endtask

  // register access: setup cycle, then access cycle
  task automatic cfg_access(input logic wr, input logic [APB_AW-1:0] addr,
                            input logic [APB_DW-1:0] data);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= wr;
    cfg_paddr   <= addr;
    cfg_pwdata  <= data;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  // hold the source until every expected member has come out
  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (IDLE_SETTLE) @(posedge clk);
  endtask

  task automatic set_vertex_count(input int vc);
    wait_idle();
    cfg_access(1'b1, VCOUNT_ADDR, APB_DW'(vc));
    cfg_access(1'b0, VCOUNT_ADDR, '0);
  endtask

  // stimulus
  initial begin
    int       target;
    int       phase;
    int       big_phases;
    int       cnt;
    int       start;
    bit       complete;
    density_t dens;

    in_ch.valid     = 1'b0;
    in_ch.kind      = KIND_LOAD;
    in_ch.row_index = '0;
    in_ch.row_bits  = '0;
    out_ch.ready    = 1'b0;
    cfg_psel        = 1'b0;
    cfg_penable     = 1'b0;
    cfg_pwrite      = 1'b0;
    cfg_paddr       = '0;
    cfg_pwdata      = '0;
    items_sent      = 0;
    src_steady      = 1'b1;
    sink_steady     = 1'b1;
    rst_n           = 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset value of the vertex count
    cfg_access(1'b0, VCOUNT_ADDR, '0);

    // directed graph: vertex 0 and 15 join everything, a chain of triangles
    // between, row 7 and row 14 empty, self loops on rows 0 and 15
    for (int r = 0; r < MAX_VERTS; r++) begin
      if (r == 0 || r == 15)
        put_item(KIND_LOAD, IDX_W'(r), '1);
      else if (r == 7 || r == 14)
        put_item(KIND_LOAD, IDX_W'(r), '0);
      else
        put_item(KIND_LOAD, IDX_W'(r), ROW_W'(3 << (r + 1)));
    end
    start_search();

    // no vertices, one vertex, a few, and counts past the maximum
    set_vertex_count(0);
    start_search();
    set_vertex_count(1);
    start_search();
    set_vertex_count(4);
    start_search();
    set_vertex_count(31);
    start_search();
    set_vertex_count(17);
    start_search();

    // random phases: mostly small graphs, a few full-size sparse or complete ones
    target = items_sent + RANDOM_ITEMS;
    phase = 0;
    big_phases = 0;
    while (items_sent < target) begin
      phase++;
      if (phase % 8 == 3 && big_phases < 4) begin
        big_phases++;
        case ($urandom_range(0, 3))
          0:       set_vertex_count(16);
          1:       set_vertex_count(31);
          2:       set_vertex_count(17);
          default: set_vertex_count($urandom_range(16, 31));
        endcase
        src_steady = ($urandom_range(0, 2) == 0);
        sink_steady <= ($urandom_range(0, 2) == 0);
        complete = (big_phases == 2);
        start = $urandom_range(0, MAX_VERTS - 1);
        // full reload keeps the search small
        for (int i = 0; i < MAX_VERTS; i++) begin
          if (complete) begin
            dens = DENS_FULL;
          end else begin
            case ($urandom_range(0, 9))
              0:       dens = DENS_FULL;
              1:       dens = DENS_NONE;
              default: dens = DENS_EIGHTH;
            endcase
          end
          put_item(KIND_LOAD, IDX_W'((start + i) % MAX_VERTS), rand_row(dens));
        end
        start_search();
        start_search();
      end else begin
        set_vertex_count($urandom_range(0, 9));
        src_steady = ($urandom_range(0, 3) == 0);
        sink_steady <= ($urandom_range(0, 3) == 0);
        cnt = $urandom_range(3, 12);
        for (int i = 0; i < cnt; i++) begin
          if (i == cnt - 1 || $urandom_range(0, 4) == 0)
            start_search();
          else
            put_item(KIND_LOAD, IDX_W'($urandom), rand_row(density_t'($urandom_range(0, 5))));
        end
      end
    end

    // drain and verdict
    wait_idle();
    repeat (END_SETTLE) @(posedge clk);
    if (mismatches == 0 && outstanding == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule

[sim.f]
src/mcs_pkg.sv
src/mcs_in_if.sv
src/mcs_out_if.sv
src/mcs_seq.sv
src/mcs_dp.sv
src/max_clique_search_unit.sv
sim/max_clique_search_checker.sv
sim/max_clique_search_unit_tb.sv
